// ===== hw/rtl/tsq_pkg.sv =====
// ----------------------------------------------------------------------------
// tsq_pkg
// shared types and constants of the tlb shootdown queue
// ----------------------------------------------------------------------------
package tsq_pkg;

    // fixed field widths of the ports
    localparam int ADDR_W    = 48;
    localparam int CPU_IDX_W = 3;
    localparam int CFG_W     = 4;

    // reset value of the cpus_in_use register
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd1;

    // depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // operation kinds
    localparam logic KIND_INVLPG = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;

    // command codes
    localparam logic CMD_BCAST = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // classified command as handed from front to back
    typedef struct packed {
        logic                 is_drain;
        logic                 drain_ok;
        logic [CPU_IDX_W-1:0] cpu;
        logic [ADDR_W-1:0]    addr;
    } op_t;

    // status of the back part
    typedef struct packed {
        logic emitting;
        logic popping;
        logic len_ok;
    } back_stat_t;

endpackage

// ===== hw/rtl/tsq_ram.sv =====
// ----------------------------------------------------------------------------
// tsq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/tsq_fifo.sv =====
// ----------------------------------------------------------------------------
// tsq_fifo
// short queue of classified commands between front and back
// ----------------------------------------------------------------------------
module tsq_fifo
    import tsq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_data,
    output logic full,
    input  logic pop,
    output op_t  pop_data,
    output logic empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    op_t              entries_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tsq_front.sv =====
// ----------------------------------------------------------------------------
// tsq_front
// accepts input beats, classifies them and queues them for the back part
// ----------------------------------------------------------------------------
module tsq_front
    import tsq_pkg::*;
#(
    parameter int NUM_CPUS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [ADDR_W-1:0]    page_address,
    input  logic [CPU_IDX_W-1:0] cpu_index,
    output logic                 op_valid,
    input  logic                 op_ready,
    output op_t                  op
);

    // address bits kept in the queues
    localparam int SA = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;

    op_t  cls;
    logic fifo_full;
    logic fifo_empty;

    always_comb
    begin
        cls.is_drain = (command == CMD_DRAIN);
        cls.drain_ok = (32'(cpu_index) < NUM_CPUS);
        cls.cpu      = cpu_index;
        for (int b = 0; b < ADDR_W; b++)
        begin
            cls.addr[b] = page_address[b] & (b < SA);
        end
    end

    assign in_ready = !fifo_full;
    assign op_valid = !fifo_empty;

    tsq_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (cls),
        .full      (fifo_full),
        .pop       (op_valid && op_ready),
        .pop_data  (op),
        .empty     (fifo_empty)
    );

endmodule

// ===== hw/rtl/tsq_back.sv =====
// ----------------------------------------------------------------------------
// tsq_back
// per-processor queues: applies broadcasts and drains one queue to the output
// ----------------------------------------------------------------------------
module tsq_back
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_CPUS    = 8,
    parameter int ADDR_BITS   = 48
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CFG_W-1:0]  cpus_in_use,
    input  logic              op_valid,
    output logic              op_ready,
    input  op_t               op,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              op_kind,
    output logic [ADDR_W-1:0] op_address,
    output logic              is_last,
    output back_stat_t        stat
);

    localparam int SA    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int ENT_W = SA + 1;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                state_reg, state_next;
    logic [LEN_W-1:0]    len_reg [NUM_CPUS];
    logic [LEN_W-1:0]    len_next [NUM_CPUS];
    logic [NUM_CPUS-1:0] flush_reg, flush_next;
    logic [CPU_W-1:0]    drain_cpu_reg, drain_cpu_next;
    logic [LEN_W-1:0]    drain_len_reg, drain_len_next;
    logic [LEN_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic                out_last_reg, out_last_next;

    logic                head_in_range;
    logic [CPU_W-1:0]    head_cpu;
    logic [LEN_W-1:0]    head_len;
    logic                pop;
    logic                bcast;
    logic                start;
    logic                out_free;
    logic                emit;
    logic                last;
    logic                rd_any;
    logic [CPU_W-1:0]    rd_cpu;
    logic [IDX_W-1:0]    rd_addr;
    logic [ENT_W-1:0]    rd_sel;
    logic                len_ok;

    logic [NUM_CPUS-1:0] wr_en;
    logic [NUM_CPUS-1:0] full_q;
    logic [IDX_W-1:0]    wr_addr [NUM_CPUS];
    logic [ENT_W-1:0]    wr_data [NUM_CPUS];
    logic [NUM_CPUS-1:0] rd_en;
    logic [ENT_W-1:0]    rd_data [NUM_CPUS];

    assign head_cpu      = CPU_W'(op.cpu);
    assign head_in_range = op.drain_ok;
    assign head_len      = head_in_range ? len_reg[head_cpu] : '0;
    assign pop           = (state_reg == ST_IDLE) && op_valid;
    assign op_ready      = (state_reg == ST_IDLE);
    assign bcast         = pop && !op.is_drain;
    assign start         = pop && op.is_drain && head_in_range && (head_len != '0);
    assign out_free      = !out_valid_reg || out_ready;
    assign emit          = (state_reg == ST_EMIT) && out_free;
    assign last          = (idx_reg == LEN_W'(drain_len_reg - 1'b1));
    assign rd_any        = start || (emit && !last);
    assign rd_cpu        = start ? head_cpu : drain_cpu_reg;
    assign rd_addr       = start ? '0 : IDX_W'(idx_reg + 1'b1);
    assign rd_sel        = rd_data[drain_cpu_reg];

    // per-queue write side of a broadcast
    always_comb
    begin
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            full_q[c]  = (len_reg[c] == LEN_W'(QUEUE_DEPTH));
            wr_en[c]   = bcast && (c < int'(cpus_in_use)) && (full_q[c] || !flush_reg[c]);
            wr_addr[c] = full_q[c] ? '0 : len_reg[c][IDX_W-1:0];
            wr_data[c] = full_q[c] ? {KIND_FLUSH, {SA{1'b0}}}
                                   : {KIND_INVLPG, op.addr[SA-1:0]};
            rd_en[c]   = rd_any && (rd_cpu == CPU_W'(c));
        end
    end

    always_comb
    begin
        len_ok = 1'b1;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            len_ok = len_ok && (len_reg[c] <= LEN_W'(QUEUE_DEPTH));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        flush_next     = flush_reg;
        drain_cpu_next = drain_cpu_reg;
        drain_len_next = drain_len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_addr_next  = out_addr_reg;
        out_last_next  = out_last_reg;

        for (int c = 0; c < NUM_CPUS; c++)
        begin
            if (wr_en[c])
            begin
                if (full_q[c])
                begin
                    len_next[c]   = LEN_W'(1);
                    flush_next[c] = 1'b1;
                end
                else
                begin
                    len_next[c] = LEN_W'(len_reg[c] + 1'b1);
                end
            end
        end

        if (start)
        begin
            state_next     = ST_EMIT;
            drain_cpu_next = head_cpu;
            drain_len_next = head_len;
            idx_next       = '0;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = rd_sel[ENT_W-1];
            out_addr_next  = (rd_sel[ENT_W-1] == KIND_FLUSH) ? '0 : ADDR_W'(rd_sel[SA-1:0]);
            out_last_next  = last;
            if (last)
            begin
                state_next                = ST_IDLE;
                len_next[drain_cpu_reg]   = '0;
                flush_next[drain_cpu_reg] = 1'b0;
            end
            else
            begin
                idx_next = LEN_W'(idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            flush_reg     <= '0;
            drain_cpu_reg <= '0;
            drain_len_reg <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                len_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            flush_reg     <= flush_next;
            drain_cpu_reg <= drain_cpu_next;
            drain_len_reg <= drain_len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_addr_reg <= out_addr_next;
        out_last_reg <= out_last_next;
    end

    // one entry store per processor
    for (genvar g = 0; g < NUM_CPUS; g++)
    begin : g_queue
        tsq_ram #(
            .WIDTH (ENT_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[g]),
            .wr_addr (wr_addr[g]),
            .wr_data (wr_data[g]),
            .rd_en   (rd_en[g]),
            .rd_addr (rd_addr),
            .rd_data (rd_data[g])
        );
    end

    assign out_valid     = out_valid_reg;
    assign op_kind       = out_kind_reg;
    assign op_address    = out_addr_reg;
    assign is_last       = out_last_reg;
    assign stat.emitting = (state_reg == ST_EMIT);
    assign stat.popping  = pop;
    assign stat.len_ok   = len_ok;

endmodule

// ===== hw/rtl/tlb_shootdown_queue_core.sv =====
// drain path: front fifo, then the entry ram's read register, then the output register
// broadcast: applied to all in-use queues at once by the back part, no output
// drain: entries leave their queue ram in order, one per cycle unless output stalls
// each processor's entry ram has one read port; no command is taken during a drain
// reset: all queues empty, cpus_in_use = 1, entry contents undefined until written
// ----------------------------------------------------------------------------
// tlb_shootdown_queue_core
// per-processor tlb invalidation queues with broadcast append and drain
// ----------------------------------------------------------------------------
module tlb_shootdown_queue_core
    import tsq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_CPUS    = 8,
    parameter int ADDR_BITS   = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    // command channel
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [ADDR_W-1:0]    page_address,
    input  logic [CPU_IDX_W-1:0] cpu_index,
    // operation channel
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 op_kind,
    output logic [ADDR_W-1:0]    op_address,
    output logic                 is_last
);

    // cpus_in_use register, written in a single beat
    logic [CFG_W-1:0] cpus_in_use_reg, cpus_in_use_next;

    // front to back queue head
    logic       op_valid;
    logic       op_ready;
    op_t        op;
    back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cpus_in_use_next = cpus_in_use_reg;
        if (cfg_valid && cfg_ready)
        begin
            cpus_in_use_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpus_in_use_reg <= CFG_RESET;
        end
        else
        begin
            cpus_in_use_reg <= cpus_in_use_next;
        end
    end

    // front: takes command beats, masks the address, checks the drain target
    tsq_front #(
        .NUM_CPUS  (NUM_CPUS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .page_address (page_address),
        .cpu_index    (cpu_index),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (op)
    );

    // back: owns the queues, applies broadcasts, streams drains out
    tsq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CPUS    (NUM_CPUS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cpus_in_use (cpus_in_use_reg),
        .op_valid    (op_valid),
        .op_ready    (op_ready),
        .op          (op),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .op_kind     (op_kind),
        .op_address  (op_address),
        .is_last     (is_last),
        .stat        (back_stat)
    );

    // no new command is taken while a drain is streaming
    assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.emitting |-> !back_stat.popping)
        else $error("back popped a command during a drain");

    // a queue never holds more entries than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.len_ok)
        else $error("queue length above depth");

    // an output beat only appears out of a drain
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(back_stat.emitting))
        else $error("output beat without a drain in progress");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tlb shootdown queue: commands are streamed in
// through a clocked driver, each accepted beat updates a local copy of every
// processor's invalidation queue, and the operations it predicts are compared
// field by field with what the block emits
// ----------------------------------------------------------------------------
module tb_top
    import tsq_pkg::*;
();

    localparam int QDEPTH     = 16;
    localparam int NCPU       = 8;
    localparam int STALL_MAX  = 2000;  // cycles with no beat on any channel
    localparam int DRAIN_WAIT = 12;    // covers the front fifo plus the back stage
    localparam int PHASE_LEN  = 32;

    // one command beat
    typedef struct packed {
        logic                 cmd;
        logic [ADDR_W-1:0]    addr;
        logic [CPU_IDX_W-1:0] cpu;
    } cmd_beat_t;

    // one operation beat
    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } op_beat_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic                 command      = CMD_BCAST;
    logic [ADDR_W-1:0]    page_address = '0;
    logic [CPU_IDX_W-1:0] cpu_index    = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 op_kind;
    logic [ADDR_W-1:0]    op_address;
    logic                 is_last;

    // commands waiting for the driver, register values waiting for the cfg driver
    cmd_beat_t        cmd_backlog[$];
    logic [CFG_W-1:0] cfg_backlog[$];
    // operations the queues are known to hold for the output side
    op_beat_t         ops_due[$];

    // shadow of the block's state
    logic [CFG_W-1:0]  cpus_active;
    int unsigned       shadow_len  [NCPU];
    logic              shadow_kind [NCPU][QDEPTH];
    logic [ADDR_W-1:0] shadow_addr [NCPU][QDEPTH];

    int        mismatches = 0;
    int        cfg_writes = 0;
    int        stall_cycles = 0;
    bit        steady = 1'b0;   // no idling on either side while set
    cmd_beat_t cmd_held;
    op_beat_t  op_want;

    tlb_shootdown_queue_core #(
        .QUEUE_DEPTH (QDEPTH),
        .NUM_CPUS    (NCPU),
        .ADDR_BITS   (ADDR_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .page_address (page_address),
        .cpu_index    (cpu_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .op_kind      (op_kind),
        .op_address   (op_address),
        .is_last      (is_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // shadow queue model
    // ------------------------------------------------------------------------

    // offer one page to one processor's queue
    function automatic void offer_page(input int c, input logic [ADDR_W-1:0] addr);
        if (shadow_len[c] >= QDEPTH)
        begin
            // overflow: the whole queue turns into a single flush-all
            shadow_kind[c][0] = KIND_FLUSH;
            shadow_addr[c][0] = '0;
            shadow_len[c]     = 1;
        end
        else if (shadow_len[c] == 1 && shadow_kind[c][0] == KIND_FLUSH)
        begin
            // a pending flush already covers this page
        end
        else
        begin
            shadow_kind[c][shadow_len[c]] = KIND_INVLPG;
            shadow_addr[c][shadow_len[c]] = addr;
            shadow_len[c]++;
        end
    endfunction

    // apply one accepted command beat, queueing the operations it releases
    function automatic void shootdown_step(input cmd_beat_t b);
        int       reach;
        op_beat_t o;
        if (b.cmd == CMD_BCAST)
        begin
            // register values above the cpu count saturate
            reach = (cpus_active > NCPU) ? NCPU : cpus_active;
            for (int c = 0; c < reach; c++)
                offer_page(c, b.addr);
        end
        else
        begin
            // drain: entries leave in order, the final one marked, queue emptied
            for (int i = 0; i < shadow_len[b.cpu]; i++)
            begin
                o.kind = shadow_kind[b.cpu][i];
                o.addr = (o.kind == KIND_FLUSH) ? '0 : shadow_addr[b.cpu][i];
                o.last = (i + 1 == shadow_len[b.cpu]);
                ops_due.push_back(o);
            end
            shadow_len[b.cpu] = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // command driver: valid is held with a stable payload until the beat is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int c = 0; c < NCPU; c++)
                shadow_len[c] = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                shootdown_step(cmd_held);
            if (!in_valid || in_ready)
            begin
                // slot is free: either idle this cycle or present the next beat
                if (cmd_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 33))
                begin
                    cmd_held = cmd_backlog.pop_front();
                    in_valid     <= 1'b1;
                    command      <= cmd_held.cmd;
                    page_address <= cmd_held.addr;
                    cpu_index    <= cmd_held.cpu;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // config driver: the shadow register follows each accepted write
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid   <= 1'b0;
            cpus_active = CFG_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cpus_active = cfg_data;
                cfg_writes++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (cfg_backlog.size() != 0)
                begin
                    cfg_valid <= 1'b1;
                    cfg_data  <= cfg_backlog.pop_front();
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // operation monitor with random backpressure
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (ops_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got kind %0d addr %h last %0d",
                             $time, op_kind, op_address, is_last);
                    mismatches++;
                end
                else
                begin
                    op_want = ops_due.pop_front();
                    if (op_kind !== op_want.kind)
                    begin
                        $display("%0t: op_kind expected %0d got %0d",
                                 $time, op_want.kind, op_kind);
                        mismatches++;
                    end
                    if (op_address !== op_want.addr)
                    begin
                        $display("%0t: op_address expected %h got %h",
                                 $time, op_want.addr, op_address);
                        mismatches++;
                    end
                    if (is_last !== op_want.last)
                    begin
                        $display("%0t: is_last expected %0d got %0d",
                                 $time, op_want.last, is_last);
                        mismatches++;
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any beat on any channel counts as progress
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_MAX)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
                $display("FAILURE");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic push_bcast(input logic [ADDR_W-1:0] addr);
        cmd_beat_t b;
        b.cmd  = CMD_BCAST;
        b.addr = addr;
        b.cpu  = CPU_IDX_W'($urandom);   // don't care for a broadcast
        cmd_backlog.push_back(b);
    endtask

    task automatic push_drain(input logic [CPU_IDX_W-1:0] cpu);
        cmd_beat_t b;
        b.cmd  = CMD_DRAIN;
        b.addr = ADDR_W'({$urandom, $urandom});   // don't care for a drain
        b.cpu  = cpu;
        cmd_backlog.push_back(b);
    endtask

    function automatic logic [ADDR_W-1:0] rand_page();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '1;
        else if (r == 1)
            return '0;
        else
            return ADDR_W'({$urandom, $urandom});
    endfunction

    // wait for everything to be taken and emitted; broadcasts leave no trace
    // on the output, so give the back end time to finish its last update
    task automatic settle();
        while (cmd_backlog.size() != 0 || in_valid || ops_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // only ever called while the block is idle
    task automatic write_cpus(input logic [CFG_W-1:0] v);
        int seen;
        seen = cfg_writes;
        cfg_backlog.push_back(v);
        while (cfg_writes == seen)
            @(negedge clk);
    endtask

    // mostly bursts of broadcasts followed by a few drains, sometimes long
    // enough to overflow into a flush; the rest single random beats
    task automatic fill_random(input int n_items);
        int made;
        int burst;
        int drains;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 19)
                                                    : $urandom_range(1, 5);
                for (int k = 0; k < burst; k++)
                    push_bcast(rand_page());
                drains = $urandom_range(1, 3);
                for (int k = 0; k < drains; k++)
                    push_drain(CPU_IDX_W'($urandom_range(0, NCPU - 1)));
                made += burst + drains;
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    push_bcast(rand_page());
                else
                    push_drain(CPU_IDX_W'($urandom_range(0, NCPU - 1)));
                made++;
            end
        end
    endtask

    // register settings per random phase, extremes included
    logic [CFG_W-1:0] phase_cpus[9] = '{4'd8, 4'd15, 4'd0, 4'd1, 4'd4, 4'd7, 4'd9, 4'd2, 4'd8};

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: cpus_in_use at its reset value of one
        push_drain('0);                   // empty queue, nothing comes out
        push_bcast('1);
        push_bcast('0);
        push_drain('0);                   // two invalidations, second marked last
        push_drain(3'd7);                 // processor not in use and empty
        for (int k = 0; k < QDEPTH + 1; k++)
            push_bcast(ADDR_W'(48'h0000_5555_0000) ^ ADDR_W'(k));  // last one overflows
        push_bcast(48'hAAAA_AAAA_AAAA);   // dropped behind the pending flush
        push_drain('0);                   // a single flush-all
        settle();

        foreach (phase_cpus[p])
        begin
            write_cpus(phase_cpus[p]);
            steady = (p == 3 || p == 4);
            fill_random(PHASE_LEN);
            settle();
        end
        steady = 1'b0;

        // flush out whatever the queues still hold so it is checked as well
        for (int c = 0; c < NCPU; c++)
            push_drain(CPU_IDX_W'(c));
        settle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
